// ----- design/lrt_pkg.sv -----
// Shared constants, opcodes and the tree node word for the range assign/add/max block.
// No dependencies. NUM_ELEMENTS must be a power of two.
`default_nettype none
package lrt_pkg;
   localparam int NUM_ELEMENTS = 1024;
   localparam int ADDR_W = $clog2(NUM_ELEMENTS);
   localparam int RANGE_W = 11;
   localparam int IDX_W = (ADDR_W + 1 > RANGE_W) ? ADDR_W + 1 : RANGE_W;
   localparam int DATA_W = 32;
   localparam int NODE_AW = ADDR_W + 1;
   localparam int TREE_NODES = 2 * NUM_ELEMENTS;

   localparam logic [1:0] OP_ASSIGN = 2'd0;
   localparam logic [1:0] OP_ADD = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [DATA_W-1:0] FLOOR_VALUE = 32'hC465_3600;  // -1000000000
   localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;

   typedef logic [DATA_W-1:0] word_type;

   // pend_value is the pending assign value when pend_assign is set,
   // otherwise the pending add
   typedef struct packed {
      logic     pend_assign;
      word_type pend_value;
      word_type max_value;
   } node_type;

   localparam node_type EMPTY_NODE = '{pend_assign: 1'b0, pend_value: '0,
                                       max_value: FLOOR_VALUE};
endpackage
`default_nettype wire

// ----- design/lrt_elem_store.sv -----
// Tree node memory: one write port, one read port with registered read data.
// Depends on lrt_pkg.
`default_nettype none
module lrt_elem_store (
   input  wire logic                       clock,
   input  wire logic [lrt_pkg::NODE_AW-1:0] rd_addr,
   input  wire logic                       wr_en,
   input  wire logic [lrt_pkg::NODE_AW-1:0] wr_addr,
   input  wire lrt_pkg::node_type          wr_data,
   output lrt_pkg::node_type               rd_data
);
   lrt_pkg::node_type mem [lrt_pkg::TREE_NODES];
   lrt_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- design/lazy_range_assign_add_max_tree.sv -----
// Top level: range assign / range add / range maximum over a lazy segment tree.
// Depends on lrt_pkg and lrt_elem_store.
//
//  channel | ports                                                    | direction
//  req     | req_valid req_ready req_op req_range_start/end req_value | in
//  rsp     | rsp_valid rsp_ready rsp_range_max                        | out
//
// Each request walks the tree depth first from the root; node memory read data is
// registered. A visited node is read in ST_VISIT, then a fully covered node is
// tagged or sampled in ST_COVER and a partly covered node pushes its tag to its
// children (ST_PUSH_N, then ST_PUSH_L and ST_PUSH_R if it holds one); in assign/add
// a partly covered node's maximum is updated on the climb back (ST_PULL_L,
// ST_PULL_R). Empty or unknown requests return to idle, an empty query goes to
// ST_DONE. After reset a clearing pass writes all 2 * NUM_ELEMENTS nodes while
// req_ready stays low. A query result waits in an output register; the block takes
// the next request while it waits and stalls only if a second query finishes first.
`default_nettype none
module lazy_range_assign_add_max_tree (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_op,
   input  wire logic [lrt_pkg::RANGE_W-1:0] req_range_start,
   input  wire logic [lrt_pkg::RANGE_W-1:0] req_range_end,
   input  wire logic signed [31:0]         req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [31:0]              rsp_range_max
);
   localparam int IW = lrt_pkg::IDX_W;
   localparam int NAW = lrt_pkg::NODE_AW;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_VISIT = 4'd2;
   localparam logic [3:0] ST_COVER = 4'd3;
   localparam logic [3:0] ST_PUSH_N = 4'd4;
   localparam logic [3:0] ST_PUSH_L = 4'd5;
   localparam logic [3:0] ST_PUSH_R = 4'd6;
   localparam logic [3:0] ST_RET = 4'd7;
   localparam logic [3:0] ST_PULL_L = 4'd8;
   localparam logic [3:0] ST_PULL_R = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [NAW-1:0]    node_ff, node_in;
   logic [IW-1:0]     lo_ff, lo_in;
   logic [IW-1:0]     size_ff, size_in;
   logic [IW-1:0]     start_ff, start_in;
   logic [IW-1:0]     end_ff, end_in;
   logic [1:0]        op_ff, op_in;
   lrt_pkg::word_type value_ff, value_in;
   lrt_pkg::word_type acc_ff, acc_in;
   logic              pend_assign_ff, pend_assign_in;
   lrt_pkg::word_type pend_value_ff, pend_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lrt_pkg::word_type rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [NAW-1:0]    wr_addr;
   logic [NAW-1:0]    rd_addr;
   lrt_pkg::node_type wr_data;
   lrt_pkg::node_type rd_data;
   logic [IW-1:0]     req_start_ext, req_end_ext, req_end_clip;
   logic [IW-1:0]     hi;
   logic [NAW-1:0]    left_node, right_node;
   logic              disjoint, covered, is_query;
   logic              rsp_free;

   // tag a node with an assign (set_value) or an add of x
   function automatic lrt_pkg::node_type apply_tag(input lrt_pkg::node_type cur,
                                                   input logic set_value,
                                                   input lrt_pkg::word_type x);
      lrt_pkg::node_type res;
      if (set_value) begin
         res.pend_assign = 1'b1;
         res.pend_value = x;
         res.max_value = x;
      end else begin
         res.pend_assign = cur.pend_assign;
         res.pend_value = cur.pend_value + x;
         res.max_value = cur.max_value + x;
      end
      return res;
   endfunction

   function automatic lrt_pkg::word_type smax(input lrt_pkg::word_type a,
                                              input lrt_pkg::word_type b);
      return ($signed(a) >= $signed(b)) ? a : b;
   endfunction

   lrt_elem_store u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign req_start_ext = IW'(req_range_start);
   assign req_end_ext = IW'(req_range_end);
   // clip the range end to the array size
   assign req_end_clip = (req_end_ext > IW'(lrt_pkg::NUM_ELEMENTS)) ?
                         IW'(lrt_pkg::NUM_ELEMENTS) : req_end_ext;
   assign hi = lo_ff + size_ff;
   assign disjoint = (end_ff <= lo_ff) || (hi <= start_ff);
   assign covered = (start_ff <= lo_ff) && (hi <= end_ff);
   assign is_query = (op_ff == lrt_pkg::OP_QUERY);
   // only partly covered nodes have children visited, and they are never leaves
   assign left_node = {node_ff[NAW-2:0], 1'b0};
   assign right_node = {node_ff[NAW-2:0], 1'b1};
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_range_max = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      node_in = node_ff;
      lo_in = lo_ff;
      size_in = size_ff;
      start_in = start_ff;
      end_in = end_ff;
      op_in = op_ff;
      value_in = value_ff;
      acc_in = acc_ff;
      pend_assign_in = pend_assign_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      rd_addr = node_ff;
      wr_en = 1'b0;
      wr_addr = node_ff;
      wr_data = lrt_pkg::EMPTY_NODE;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            node_in = node_ff + NAW'(1);
            if (node_ff == NAW'(lrt_pkg::TREE_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               start_in = req_start_ext;
               end_in = req_end_clip;
               op_in = req_op;
               value_in = req_value;
               node_in = NAW'(1);
               lo_in = '0;
               size_in = IW'(lrt_pkg::NUM_ELEMENTS);
               acc_in = lrt_pkg::MOST_NEGATIVE;
               if ((req_op == lrt_pkg::OP_ASSIGN || req_op == lrt_pkg::OP_ADD ||
                    req_op == lrt_pkg::OP_QUERY) && (req_start_ext < req_end_clip)) begin
                  state_in = ST_VISIT;
               end else if (req_op == lrt_pkg::OP_QUERY) begin
                  acc_in = lrt_pkg::FLOOR_VALUE;
                  state_in = ST_DONE;
               end
            end
         end
         ST_VISIT: begin
            // read the node; a disjoint node contributes the floor to a query
            if (disjoint) begin
               if (is_query) begin
                  acc_in = smax(acc_ff, lrt_pkg::FLOOR_VALUE);
               end
               state_in = ST_RET;
            end else if (covered) begin
               state_in = ST_COVER;
            end else begin
               state_in = ST_PUSH_N;
            end
         end
         ST_COVER: begin
            if (is_query) begin
               acc_in = smax(acc_ff, rd_data.max_value);
            end else begin
               wr_en = 1'b1;
               wr_data = apply_tag(rd_data, op_ff == lrt_pkg::OP_ASSIGN, value_ff);
            end
            state_in = ST_RET;
         end
         ST_PUSH_N: begin
            // hold the node's tag; if it has one, clear it in memory and tag both children
            pend_assign_in = rd_data.pend_assign;
            pend_value_in = rd_data.pend_value;
            if (rd_data.pend_assign || (rd_data.pend_value != '0)) begin
               wr_en = 1'b1;
               wr_data.max_value = rd_data.max_value;
               rd_addr = left_node;
               state_in = ST_PUSH_L;
            end else begin
               node_in = left_node;
               size_in = size_ff >> 1;
               state_in = ST_VISIT;
            end
         end
         ST_PUSH_L: begin
            wr_en = 1'b1;
            wr_addr = left_node;
            wr_data = apply_tag(rd_data, pend_assign_ff, pend_value_ff);
            rd_addr = right_node;
            state_in = ST_PUSH_R;
         end
         ST_PUSH_R: begin
            wr_en = 1'b1;
            wr_addr = right_node;
            wr_data = apply_tag(rd_data, pend_assign_ff, pend_value_ff);
            node_in = left_node;
            size_in = size_ff >> 1;
            state_in = ST_VISIT;
         end
         ST_RET: begin
            // finish at the root, else advance to the right sibling or climb to the parent
            if (node_ff == NAW'(1)) begin
               state_in = is_query ? ST_DONE : ST_IDLE;
            end else if (!node_ff[0]) begin
               node_in = node_ff + NAW'(1);
               lo_in = lo_ff + size_ff;
               state_in = ST_VISIT;
            end else begin
               node_in = node_ff >> 1;
               size_in = size_ff << 1;
               lo_in = lo_ff - size_ff;
               if (!is_query) begin
                  rd_addr = node_ff - NAW'(1);
                  state_in = ST_PULL_L;
               end
            end
         end
         ST_PULL_L: begin
            acc_in = rd_data.max_value;
            rd_addr = right_node;
            state_in = ST_PULL_R;
         end
         ST_PULL_R: begin
            wr_en = 1'b1;
            wr_data.max_value = smax(acc_ff, rd_data.max_value);
            state_in = ST_RET;
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = acc_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         node_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_ff <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in;
      size_ff <= size_in;
      start_ff <= start_in;
      end_ff <= end_in;
      op_ff <= op_in;
      value_ff <= value_in;
      acc_ff <= acc_in;
      pend_assign_ff <= pend_assign_in;
      pend_value_ff <= pend_value_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire
